FILE: sv/scsc_pkg.sv
// Package for the solar charger surplus controller: types, codes and constants.
// Used by every module of the block; no dependencies.
package scsc_pkg;

  localparam int TIME_BITS = 32;

  typedef logic [TIME_BITS-1:0] time_t;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_MANUAL = 1'b1
  } op_t;

  localparam logic [2:0] REG_REST1     = 3'd0;
  localparam logic [2:0] REG_REST2     = 3'd1;
  localparam logic [2:0] REG_CHECK     = 3'd2;
  localparam logic [2:0] REG_CAR       = 3'd3;
  localparam logic [2:0] REG_START_W   = 3'd4;
  localparam logic [2:0] REG_STOP_W    = 3'd5;
  localparam logic [2:0] REG_OFF_LIMIT = 3'd6;
  localparam logic [2:0] REG_MODE      = 3'd7;

  localparam int DUTY_STEPS = 11;
  localparam logic [9:0] DUTY_MAX = 10'd1023;
  localparam logic [9:0] DUTY_LV [DUTY_STEPS] = '{
    10'd0, 10'd100, 10'd200, 10'd300, 10'd400, 10'd500,
    10'd600, 10'd700, 10'd800, 10'd900, 10'd950
  };

  localparam logic signed [16:0] CH1_ON_W   = 17'sd600;
  localparam logic signed [16:0] CH1_OFF_W  = -17'sd300;
  localparam logic signed [16:0] CH2_ON_W   = 17'sd30;
  localparam logic signed [16:0] CH2_OFF_W  = -17'sd400;
  localparam logic [14:0]        BATT_MIN_W = 15'd100;
  localparam logic [3:0]         CAR_COUNT  = 4'd10;
  localparam logic [3:0]         CNT_MAX    = 4'd15;

  typedef struct packed {
    op_t                op;
    logic [31:0]        time_ms;
    logic signed [15:0] net_power_w;
    logic [14:0]        delivered_power_w;
    logic               battery_running;
    logic               charger_index;
    logic               switch_on;
    logic               manual_override;
  } item_t;

  typedef struct packed {
    logic       power_relay_closed;
    logic       remote1_relay_closed;
    logic       charger2_relay_closed;
    logic       led_one;
    logic       led_two;
    logic [9:0] pwm_duty;
    logic       car_start_cmd;
    logic       car_stop_cmd;
    logic       grid_priority_req;
    logic       check_skipped;
  } result_t;

  typedef struct packed {
    logic [31:0]        rest1;
    logic [31:0]        rest2;
    logic [31:0]        check;
    logic [31:0]        car;
    logic signed [15:0] start_w;
    logic signed [15:0] stop_w;
    logic [7:0]         off_limit;
    logic [1:0]         mode;
  } cfg_t;

  // Zero-extend or truncate a 32-bit value to the time width.
  function automatic time_t to_time(logic [31:0] v);
    logic [TIME_BITS+31:0] w;
    w = {{TIME_BITS{1'b0}}, v};
    return w[TIME_BITS-1:0];
  endfunction

endpackage

FILE: sv/scsc_cfg.sv
// Configuration register file with APB-style access.
// Depends on scsc_pkg.
module scsc_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output scsc_pkg::cfg_t      cfg
);
  import scsc_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign idx = paddr[4:2];
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (idx)
        REG_REST1:     cfg_nxt.rest1 = pwdata;
        REG_REST2:     cfg_nxt.rest2 = pwdata;
        REG_CHECK:     cfg_nxt.check = pwdata;
        REG_CAR:       cfg_nxt.car = pwdata;
        REG_START_W:   cfg_nxt.start_w = pwdata[15:0];
        REG_STOP_W:    cfg_nxt.stop_w = pwdata[15:0];
        REG_OFF_LIMIT: cfg_nxt.off_limit = pwdata[7:0];
        REG_MODE:      cfg_nxt.mode = pwdata[1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_REST1:     prdata = cfg_r.rest1;
      REG_REST2:     prdata = cfg_r.rest2;
      REG_CHECK:     prdata = cfg_r.check;
      REG_CAR:       prdata = cfg_r.car;
      REG_START_W:   prdata = {{16{cfg_r.start_w[15]}}, cfg_r.start_w};
      REG_STOP_W:    prdata = {{16{cfg_r.stop_w[15]}}, cfg_r.stop_w};
      REG_OFF_LIMIT: prdata = {24'd0, cfg_r.off_limit};
      REG_MODE:      prdata = {30'd0, cfg_r.mode};
      default:       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rest1     <= 32'd30000;
      cfg_r.rest2     <= 32'd30000;
      cfg_r.check     <= 32'd10000;
      cfg_r.car       <= 32'd60000;
      cfg_r.start_w   <= 16'sd500;
      cfg_r.stop_w    <= -16'sd1000;
      cfg_r.off_limit <= 8'd3;
      cfg_r.mode      <= 2'd1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: sv/scsc_front.sv
// Front end: accepts items, classifies the operation, queues them for the back end.
// Depends on scsc_pkg.
module scsc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  logic                op_bit,
  input  logic [31:0]         time_ms,
  input  logic signed [15:0]  net_power_w,
  input  logic [14:0]         delivered_power_w,
  input  logic                battery_running,
  input  logic                charger_index,
  input  logic                switch_on,
  input  logic                manual_override,
  output logic                valid,
  output scsc_pkg::item_t     item,
  input  logic                take
);
  import scsc_pkg::*;

  item_t slot_r [2];
  logic  wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic  wr, rd;
  item_t cls;

  always_comb begin
    cls.op                = op_bit ? OP_MANUAL : OP_SAMPLE;
    cls.time_ms           = time_ms;
    cls.net_power_w       = net_power_w;
    cls.delivered_power_w = delivered_power_w;
    cls.battery_running   = battery_running;
    cls.charger_index     = charger_index;
    cls.switch_on         = switch_on;
    cls.manual_override   = manual_override;
  end

  assign full  = cnt_r[1];
  assign valid = cnt_r != 2'd0;
  assign item  = slot_r[rp_r];
  assign wr    = push && !full;
  assign rd    = take && valid;
  assign cnt_nxt = cnt_r + {1'b0, wr} - {1'b0, rd};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) slot_r[wp_r] <= cls;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("input queue count out of range");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (full && !rd) |=> full) else $error("input queue lost an entry");
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd1 && rd && !wr) |=> !valid) else $error("input queue count slip");

endmodule

FILE: sv/scsc_back.sv
// Back end: controller state and per-item evaluation, one item a cycle while the result queue has room.
// Depends on scsc_pkg.
module scsc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  scsc_pkg::cfg_t      cfg,
  input  logic                valid,
  input  scsc_pkg::item_t     item,
  output logic                take,
  input  logic                res_full,
  output logic                res_push,
  output scsc_pkg::result_t   res
);
  import scsc_pkg::*;

  typedef struct packed {
    logic [2:0] relay;   // bit0 power, bit1 remote1, bit2 charger two
    logic [1:0] ovl;
    time_t      st0;
    time_t      st1;
    logic [1:0] ns;
  } sw_t;

  sw_t  sw_r, sw_nxt;
  logic signed [8:0] oc0_r, oc0_nxt, oc1_r, oc1_nxt;
  logic [9:0] duty_r, duty_nxt;
  time_t lct_r, lct_nxt, lcar_r, lcar_nxt;
  logic [3:0] hc_r, hc_nxt, lc_r, lc_nxt;
  logic car_r, car_nxt;
  logic fire;

  function automatic logic ch_on(logic [2:0] r, logic n);
    return n ? r[2] : (r[0] && r[1]);
  endfunction

  function automatic sw_t toggle(sw_t s, logic n, logic on, logic ovr, time_t t);
    sw_t o;
    logic is_on;
    o = s;
    is_on = ch_on(s.relay, n);
    if (is_on != on) begin
      if (is_on) begin
        if (ovr) o.ovl[n] = 1'b0;
        if (ovr || !o.ovl[n]) begin
          if (n) o.relay[2] = 1'b0;
          else   o.relay[1] = 1'b0;
        end
      end else begin
        if (ovr) o.ovl[n] = 1'b1;
        if (n) o.relay[2] = 1'b1;
        else   o.relay[1:0] = 2'b11;
      end
      if (n) o.st1 = t;
      else   o.st0 = t;
      o.ns[n] = 1'b0;
    end
    return o;
  endfunction

  function automatic logic [9:0] duty_from(logic signed [16:0] net, logic [9:0] duty);
    logic signed [18:0] d;
    logic [9:0] lv;
    d = 19'(2 * net) + $signed({9'd0, duty});
    lv = DUTY_MAX;
    for (int i = DUTY_STEPS - 1; i >= 0; i--) begin
      if (d < 19'(100 * (i + 1))) lv = DUTY_LV[i];
    end
    return lv;
  endfunction

  assign take = valid && !res_full;
  assign fire = take;
  assign res_push = fire;

  always_comb begin
    time_t t, now, rest0, rest1, cchk, ccar;
    logic s1, s2, ok0, ok1, skip_rest;
    logic signed [16:0] net;
    sw_nxt = sw_r; oc0_nxt = oc0_r; oc1_nxt = oc1_r; duty_nxt = duty_r;
    lct_nxt = lct_r; lcar_nxt = lcar_r; hc_nxt = hc_r; lc_nxt = lc_r; car_nxt = car_r;
    res = '0;
    t = to_time(item.time_ms);
    rest0 = to_time(cfg.rest1);
    rest1 = to_time(cfg.rest2);
    cchk = to_time(cfg.check);
    ccar = to_time(cfg.car);
    net = 17'(item.net_power_w);
    s1 = ch_on(sw_r.relay, 1'b0);
    s2 = ch_on(sw_r.relay, 1'b1);
    skip_rest = 1'b0;
    ok0 = 1'b0;
    ok1 = 1'b0;
    now = '0;
    if (item.op == OP_MANUAL) begin
      sw_nxt = toggle(sw_r, item.charger_index, item.switch_on, item.manual_override, t);
    end else begin
      // car charge start/stop hysteresis
      now = t + ccar;
      if ((now - lcar_r) > ccar) begin
        if (s1 && s2 && duty_r == DUTY_MAX && net > 17'(cfg.start_w) && !car_r) begin
          if (hc_r >= CAR_COUNT && cfg.mode[1]) begin
            res.car_start_cmd = 1'b1;
            lcar_nxt = now;
            car_nxt = 1'b1;
            hc_nxt = 4'd0;
          end else if (hc_r < CNT_MAX) begin
            hc_nxt = hc_r + 4'd1;
          end
        end else if (net < 17'(cfg.stop_w) && car_r && cfg.mode[1]) begin
          if (lc_r >= CAR_COUNT) begin
            res.car_stop_cmd = 1'b1;
            lcar_nxt = now;
            car_nxt = 1'b0;
            lc_nxt = 4'd0;
          end else begin
            lc_nxt = lc_r + 4'd1;
          end
        end
      end
      // evaluated income check
      now = t + cchk;
      if ((now - lct_r) > cchk) begin
        lct_nxt = now;
        ok0 = sw_r.ns[0] || ((now - sw_r.st0) > rest0);
        ok1 = sw_r.ns[1] || ((now - sw_r.st1) > rest1);
        if (ok0) begin
          if (!s1) begin
            if (net > CH1_ON_W) begin
              net = net - CH1_ON_W;
              sw_nxt = toggle(sw_nxt, 1'b0, 1'b1, 1'b0, t);
              oc0_nxt = -9'sd1;
            end
          end else if (net < CH1_OFF_W && !sw_nxt.ovl[0]) begin
            if (cfg.mode[0] && oc0_r < $signed({1'b0, cfg.off_limit})) begin
              oc0_nxt = oc0_r + 9'sd1;
            end else begin
              net = net + CH1_ON_W;
              sw_nxt = toggle(sw_nxt, 1'b0, 1'b0, 1'b0, t);
            end
          end
        end
        if (ok1) begin
          if (!s2) begin
            if (net > CH2_ON_W) begin
              if (item.battery_running && item.delivered_power_w > BATT_MIN_W) begin
                res.grid_priority_req = 1'b1;
                skip_rest = 1'b1;
              end else begin
                sw_nxt = toggle(sw_nxt, 1'b1, 1'b1, 1'b0, t);
                oc1_nxt = -9'sd1;
              end
            end
          end else if (net < CH2_OFF_W && !sw_nxt.ovl[1]) begin
            if (cfg.mode[0] && oc1_r < $signed({1'b0, cfg.off_limit})) begin
              oc1_nxt = oc1_r + 9'sd1;
            end else begin
              sw_nxt = toggle(sw_nxt, 1'b1, 1'b0, 1'b0, t);
            end
          end
        end
        if (s2 && !skip_rest) duty_nxt = duty_from(net, duty_r);
      end else begin
        res.check_skipped = 1'b1;
      end
    end
    res.power_relay_closed    = sw_nxt.relay[0];
    res.remote1_relay_closed  = sw_nxt.relay[1];
    res.charger2_relay_closed = sw_nxt.relay[2];
    res.led_one               = ch_on(sw_nxt.relay, 1'b0);
    res.led_two               = ch_on(sw_nxt.relay, 1'b1);
    res.pwm_duty              = duty_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r.relay <= 3'b000;
      sw_r.ovl   <= 2'b00;
      sw_r.st0   <= '0;
      sw_r.st1   <= '0;
      sw_r.ns    <= 2'b11;
      oc0_r      <= -9'sd1;
      oc1_r      <= -9'sd1;
      duty_r     <= 10'd0;
      lct_r      <= '0;
      lcar_r     <= '0;
      hc_r       <= 4'd0;
      lc_r       <= 4'd0;
      car_r      <= 1'b0;
    end else if (fire) begin
      sw_r   <= sw_nxt;
      oc0_r  <= oc0_nxt;
      oc1_r  <= oc1_nxt;
      duty_r <= duty_nxt;
      lct_r  <= lct_nxt;
      lcar_r <= lcar_nxt;
      hc_r   <= hc_nxt;
      lc_r   <= lc_nxt;
      car_r  <= car_nxt;
    end
  end

  a_start_sets: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res.car_start_cmd) |=> car_r) else $error("car start without charging flag");
  a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res.car_stop_cmd) |=> !car_r) else $error("car stop left charging flag");
  a_manual_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && item.op == OP_MANUAL) |-> !(res.car_start_cmd || res.car_stop_cmd
      || res.grid_priority_req || res.check_skipped)) else $error("pulse on manual command");
  a_duty_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res.check_skipped) |=> $stable(duty_r)) else $error("duty moved on skipped check");

endmodule

FILE: sv/scsc_out_q.sv
// Result queue: two entries between the back end and the result ports.
// Depends on scsc_pkg.
module scsc_out_q (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  scsc_pkg::result_t   din,
  output logic                full,
  output logic                empty,
  output scsc_pkg::result_t   dout,
  input  logic                pop
);
  import scsc_pkg::*;

  result_t slot_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic wr, rd;

  assign full  = cnt_r[1];
  assign empty = cnt_r == 2'd0;
  assign dout  = slot_r[rp_r];
  assign wr    = push && !full;
  assign rd    = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk) begin
    if (wr) slot_r[wp_r] <= din;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full)) else $error("result pushed into full queue");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("result queue count out of range");
  a_keep: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !rd) |=> !empty) else $error("result queue dropped an entry");

endmodule

FILE: sv/solar_charger_surplus_controller_core.sv
// Top level of the solar charger surplus controller.
// Depends on scsc_pkg, scsc_cfg, scsc_front, scsc_back, scsc_out_q.

// Every transaction on the input queue (an income sample or a manual switch
// command) yields exactly one result transaction, in order. Items are taken
// one per clock while the input queue is not full: the front end queues and
// classifies up to two items, the back end evaluates one item per cycle (the
// sustained rate) against the controller state while the result queue has
// room, and a two-entry result queue holds finished results, so a new item is
// accepted while an earlier result waits to be popped. An item is registered
// in the input queue, evaluated combinationally and registered in the result
// queue. The user must write configuration over the APB-style port only while
// the block is idle; the block itself does not enforce this. Registers sit at
// byte address 4*index and read back their value.
module solar_charger_surplus_controller_core (
  input  logic               clk,
  input  logic               rst_n,
  // input queue
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_operation,
  input  logic [31:0]        in_time_ms,
  input  logic signed [15:0] in_net_power_w,
  input  logic [14:0]        in_delivered_power_w,
  input  logic               in_battery_running,
  input  logic               in_charger_index,
  input  logic               in_switch_on,
  input  logic               in_manual_override,
  // result queue
  output logic               out_empty,
  input  logic               out_pop,
  output logic               out_power_relay_closed,
  output logic               out_remote1_relay_closed,
  output logic               out_charger2_relay_closed,
  output logic               out_led_one,
  output logic               out_led_two,
  output logic [9:0]         out_pwm_duty,
  output logic               out_car_start_cmd,
  output logic               out_car_stop_cmd,
  output logic               out_grid_priority_req,
  output logic               out_check_skipped,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import scsc_pkg::*;

  cfg_t    cfg;
  item_t   item;
  result_t res, res_q;
  logic    item_valid, item_take, res_push, res_full;

  scsc_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  // front end: queue and classify incoming transactions
  scsc_front u_front (
    .clk, .rst_n,
    .push              (in_push),
    .full              (in_full),
    .op_bit            (in_operation),
    .time_ms           (in_time_ms),
    .net_power_w       (in_net_power_w),
    .delivered_power_w (in_delivered_power_w),
    .battery_running   (in_battery_running),
    .charger_index     (in_charger_index),
    .switch_on         (in_switch_on),
    .manual_override   (in_manual_override),
    .valid             (item_valid),
    .item              (item),
    .take              (item_take)
  );

  // back end: evaluates one item per cycle when the result queue has room
  scsc_back u_back (
    .clk, .rst_n, .cfg,
    .valid    (item_valid),
    .item     (item),
    .take     (item_take),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res)
  );

  scsc_out_q u_out_q (
    .clk, .rst_n,
    .push  (res_push),
    .din   (res),
    .full  (res_full),
    .empty (out_empty),
    .dout  (res_q),
    .pop   (out_pop)
  );

  assign out_power_relay_closed    = res_q.power_relay_closed;
  assign out_remote1_relay_closed  = res_q.remote1_relay_closed;
  assign out_charger2_relay_closed = res_q.charger2_relay_closed;
  assign out_led_one               = res_q.led_one;
  assign out_led_two               = res_q.led_two;
  assign out_pwm_duty              = res_q.pwm_duty;
  assign out_car_start_cmd         = res_q.car_start_cmd;
  assign out_car_stop_cmd          = res_q.car_stop_cmd;
  assign out_grid_priority_req     = res_q.grid_priority_req;
  assign out_check_skipped         = res_q.check_skipped;

endmodule

FILE: sim/tb_solar_charger_surplus_controller_core.sv
// Self-checking testbench for solar_charger_surplus_controller_core.
// Depends on scsc_pkg and the core; a built-in predictor checks every result transaction.
`timescale 1ns / 1ps

module tb_solar_charger_surplus_controller_core;
  import scsc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // input channel
  logic               in_push = 1'b0;
  logic               in_full;
  logic               in_operation = 1'b0;
  logic [31:0]        in_time_ms = '0;
  logic signed [15:0] in_net_power_w = '0;
  logic [14:0]        in_delivered_power_w = '0;
  logic               in_battery_running = 1'b0;
  logic               in_charger_index = 1'b0;
  logic               in_switch_on = 1'b0;
  logic               in_manual_override = 1'b0;
  // result channel
  logic               out_empty;
  logic               out_pop = 1'b0;
  logic               out_power_relay_closed;
  logic               out_remote1_relay_closed;
  logic               out_charger2_relay_closed;
  logic               out_led_one;
  logic               out_led_two;
  logic [9:0]         out_pwm_duty;
  logic               out_car_start_cmd;
  logic               out_car_stop_cmd;
  logic               out_grid_priority_req;
  logic               out_check_skipped;
  // config port
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  solar_charger_surplus_controller_core u_top (.*);

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------
  // Predictor state: a private copy of the controller.
  // ---------------------------------------------------------------------
  cfg_t        ctl_cfg;
  logic [2:0]  relays;          // bit0 power, bit1 remote1, bit2 charger two
  logic [1:0]  latch;           // manual override latches
  logic [31:0] last_switch [2];
  bit          untouched [2];   // charger never switched since reset
  int          low_streak [2];  // off-debounce counters
  logic [9:0]  duty;
  logic [31:0] last_eval;
  logic [31:0] last_car_cmd;
  int          surplus_run;
  int          deficit_run;
  bit          car_active;

  function automatic bit is_on(int n);
    return n == 0 ? (relays[0] && relays[1]) : relays[2];
  endfunction

  function automatic void set_charger(int n, bit on, bit ovr, logic [31:0] t);
    bit cur;
    cur = is_on(n);
    if (cur == on) return;
    if (cur) begin
      if (ovr) latch[n] = 1'b0;
      // a latched charger ignores an automatic switch-off, but the time is kept
      if (ovr || !latch[n]) begin
        if (n == 0) relays[1] = 1'b0;  // power relay stays closed
        else relays[2] = 1'b0;
      end
    end else begin
      if (ovr) latch[n] = 1'b1;
      if (n == 0) relays[1:0] = 2'b11;
      else relays[2] = 1'b1;
    end
    last_switch[n] = t;
    untouched[n] = 1'b0;
  endfunction

  // duty step from doubled watts: 2*net + current duty
  function automatic logic [9:0] duty_step(int net);
    int d;
    d = 2 * net + int'(duty);
    for (int i = 0; i < DUTY_STEPS; i++)
      if (d < 100 * (i + 1)) return DUTY_LV[i];
    return DUTY_MAX;
  endfunction

  function automatic result_t controller_next(item_t it);
    result_t     r;
    logic [31:0] t, now;
    int          net;
    bit          s1, s2, ctrl, aborted, on;
    r = '0;
    t = it.time_ms;
    net = $signed(it.net_power_w);
    aborted = 1'b0;
    if (it.op == OP_MANUAL) begin
      set_charger(int'(it.charger_index), it.switch_on, it.manual_override, t);
    end else begin
      s1 = is_on(0);
      s2 = is_on(1);
      ctrl = ctl_cfg.mode[1];
      // car charge hysteresis
      now = t + ctl_cfg.car;
      if (now - last_car_cmd > ctl_cfg.car) begin
        if (s1 && s2 && duty == DUTY_MAX && net > int'(ctl_cfg.start_w) && !car_active) begin
          if (surplus_run >= 10 && ctrl) begin
            r.car_start_cmd = 1'b1;
            last_car_cmd = now;
            car_active = 1'b1;
            surplus_run = 0;
          end else if (surplus_run < 15) begin
            surplus_run++;
          end
        end else if (net < int'(ctl_cfg.stop_w) && car_active && ctrl) begin
          if (deficit_run >= 10) begin
            r.car_stop_cmd = 1'b1;
            last_car_cmd = now;
            car_active = 1'b0;
            deficit_run = 0;
          end else begin
            deficit_run++;
          end
        end
      end
      // income check, rate limited
      now = t + ctl_cfg.check;
      if (now - last_eval > ctl_cfg.check) begin
        last_eval = now;
        for (int n = 0; n < 2 && !aborted; n++) begin
          on = n ? s2 : s1;
          if (!(untouched[n] || now - last_switch[n] > (n ? ctl_cfg.rest2 : ctl_cfg.rest1)))
            continue;
          if (!on) begin
            if (n == 0 && net > 600) begin
              net -= 600;
              set_charger(0, 1'b1, 1'b0, t);
              low_streak[0] = -1;
            end else if (n == 1 && net > 30) begin
              if (it.battery_running && it.delivered_power_w > 100) begin
                r.grid_priority_req = 1'b1;
                aborted = 1'b1;
              end else begin
                set_charger(1, 1'b1, 1'b0, t);
                low_streak[1] = -1;
              end
            end
          end else if (net < (n ? -400 : -300) && !latch[n]) begin
            if (ctl_cfg.mode[0] && low_streak[n] < int'(ctl_cfg.off_limit)) begin
              low_streak[n]++;
            end else begin
              if (n == 0) net += 600;
              set_charger(n, 1'b0, 1'b0, t);
            end
          end
        end
        if (!aborted && s2) duty = duty_step(net);
      end else begin
        r.check_skipped = 1'b1;
      end
    end
    r.power_relay_closed    = relays[0];
    r.remote1_relay_closed  = relays[1];
    r.charger2_relay_closed = relays[2];
    r.led_one               = is_on(0);
    r.led_two               = is_on(1);
    r.pwm_duty              = duty;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Queues, knobs and counters
  // ---------------------------------------------------------------------
  item_t       queued_items [$];
  result_t     pending_results [$];
  item_t       offered;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          holdoff_req = 1'b0;
  bit          holdoff_done = 1'b0;
  int          holdoff_left = 0;
  int          cycles = 0;
  int          n_accepted = 0;
  int          n_results = 0;
  int          n_mismatch = 0;
  int          n_car_start = 0;
  int          n_car_stop = 0;
  int          n_grid = 0;
  int          n_stalled = 0;
  bit          failed = 1'b0;
  logic [31:0] clock_ms = 32'd1;

  // Driver: present the next item, hold it while the queue is full.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && in_full) n_stalled++;
      if (in_push && !in_full) begin
        pending_results.push_back(controller_next(offered));
        n_accepted++;
      end
      if (!(in_push && in_full)) begin
        if (queued_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          offered = queued_items.pop_front();
          in_push              <= 1'b1;
          in_operation         <= offered.op;
          in_time_ms           <= offered.time_ms;
          in_net_power_w       <= offered.net_power_w;
          in_delivered_power_w <= offered.delivered_power_w;
          in_battery_running   <= offered.battery_running;
          in_charger_index     <= offered.charger_index;
          in_switch_on         <= offered.switch_on;
          in_manual_override   <= offered.manual_override;
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted in its own process.
  always @(posedge clk) begin
    if (holdoff_req && !holdoff_done) begin
      holdoff_left <= 400;
      holdoff_done <= 1'b1;
    end else if (holdoff_left > 0) begin
      holdoff_left <= holdoff_left - 1;
    end
  end

  // Monitor: compare each popped transaction with the oldest prediction.
  always @(posedge clk) begin
    result_t got, want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        got = '{out_power_relay_closed, out_remote1_relay_closed, out_charger2_relay_closed,
                out_led_one, out_led_two, out_pwm_duty, out_car_start_cmd,
                out_car_stop_cmd, out_grid_priority_req, out_check_skipped};
        n_results++;
        n_car_start += got.car_start_cmd;
        n_car_stop  += got.car_stop_cmd;
        n_grid      += got.grid_priority_req;
        if (pending_results.size() == 0) begin
          failed = 1'b1;
          n_mismatch++;
          if (n_mismatch <= 10) $display("unexpected result transaction: %p", got);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            failed = 1'b1;
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("mismatch at result %0d\n  expected %p\n  actual   %p",
                       n_results, want, got);
          end
        end
      end
      out_pop <= (holdoff_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, pending_results.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic item_t make_item(op_t op, logic [31:0] t, int net, int dlv,
                                      bit batt, bit idx, bit on, bit ovr);
    item_t it;
    it.op = op;
    it.time_ms = t;
    it.net_power_w = net[15:0];
    it.delivered_power_w = dlv[14:0];
    it.battery_running = batt;
    it.charger_index = idx;
    it.switch_on = on;
    it.manual_override = ovr;
    return it;
  endfunction

  task automatic sample(int net, bit batt = 0, int dlv = 0);
    clock_ms += 1;
    queued_items.push_back(make_item(OP_SAMPLE, clock_ms, net, dlv, batt, 0, 0, 0));
  endtask

  task automatic manual(bit idx, bit on, bit ovr);
    clock_ms += 1;
    queued_items.push_back(make_item(OP_MANUAL, clock_ms, $urandom_range(65535),
                                     $urandom_range(32767), 1'($urandom_range(1)),
                                     idx, on, ovr));
  endtask

  // Block is idle: nothing queued, nothing offered, nothing outstanding.
  task automatic wait_idle();
    while (queued_items.size() > 0 || in_push || pending_results.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_REST1:     ctl_cfg.rest1 = val;
      REG_REST2:     ctl_cfg.rest2 = val;
      REG_CHECK:     ctl_cfg.check = val;
      REG_CAR:       ctl_cfg.car = val;
      REG_START_W:   ctl_cfg.start_w = val[15:0];
      REG_STOP_W:    ctl_cfg.stop_w = val[15:0];
      REG_OFF_LIMIT: ctl_cfg.off_limit = val[7:0];
      REG_MODE:      ctl_cfg.mode = val[1:0];
      default: ;
    endcase
  endtask

  task automatic cfg_all(logic [31:0] r1, logic [31:0] r2, logic [31:0] chk, logic [31:0] car,
                         int start_w, int stop_w, int lim, int mode);
    cfg_write(REG_REST1, r1);
    cfg_write(REG_REST2, r2);
    cfg_write(REG_CHECK, chk);
    cfg_write(REG_CAR, car);
    cfg_write(REG_START_W, start_w);
    cfg_write(REG_STOP_W, stop_w);
    cfg_write(REG_OFF_LIMIT, lim);
    cfg_write(REG_MODE, mode);
  endtask

  // Mostly plausible sample streams with slowly changing weather, some manual
  // commands, and a little fully random noise.
  task automatic add_random(int n, int step_max);
    int regime, r, net;
    item_t it;
    regime = 0;
    for (int k = 0; k < n; k++) begin
      if (k % 40 == 0) regime = $urandom_range(3);
      r = $urandom_range(99);
      clock_ms += $urandom_range(step_max);
      if (r < 5) begin
        it = make_item(op_t'($urandom_range(1)), $urandom, $urandom_range(65535),
                       $urandom_range(32767), 1'($urandom_range(1)), 1'($urandom_range(1)),
                       1'($urandom_range(1)), 1'($urandom_range(1)));
      end else if (r < 15) begin
        it = make_item(OP_MANUAL, clock_ms, $urandom_range(65535), $urandom_range(32767),
                       1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                       $urandom_range(3) == 0);
      end else begin
        case (regime)
          0:       net = $urandom_range(3000) + 400;
          1:       net = -int'($urandom_range(3000));
          2:       net = int'($urandom_range(1400)) - 700;
          default: net = $urandom_range(1) ? int'($urandom_range(32767))
                                           : -int'($urandom_range(32768));
        endcase
        it = make_item(OP_SAMPLE, clock_ms, net, $urandom_range(400),
                       $urandom_range(9) == 0, 0, 0, 0);
      end
      queued_items.push_back(it);
    end
  endtask

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    ctl_cfg = '{rest1: 30000, rest2: 30000, check: 10000, car: 60000,
                start_w: 16'sd500, stop_w: -16'sd1000, off_limit: 8'd3, mode: 2'd1};
    relays = '0;
    latch = '0;
    last_switch = '{default: '0};
    untouched = '{default: 1'b1};
    low_streak = '{default: -1};
    duty = '0;
    last_eval = '0;
    last_car_cmd = '0;
    surplus_run = 0;
    deficit_run = 0;
    car_active = 1'b0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed: no rest, no interval, car control on, no debounce slack.
    cfg_all(0, 0, 0, 0, 500, -1000, 0, 3);
    manual(0, 1, 0);                // charger one on
    sample(-500);                   // low: counted, not yet off
    sample(-500);                   // charger one off, power relay stays
    manual(1, 1, 1);                // charger two on, latched
    manual(1, 0, 0);                // latched switch-off: relays unchanged
    sample(-32768);                 // latched: auto off ignored
    manual(1, 0, 1);                // override clears latch and switches off
    sample(32767, 1, 32767);        // battery running: grid priority pulse
    sample(32767, 1, 100);          // delivery at limit: charger two switches on
    repeat (13) sample(2000);       // duty to max, surplus count, car start
    clock_ms = 32'hFFFF_FFF0;
    repeat (3) sample(-32768, 0, 32767);
    wait_idle();

    // Random phases, each with its own settings and idling pattern.
    cfg_all(50, 80, 5, 3, 500, -1000, 2, 3);
    add_random(300, 12);
    wait_idle();

    send_idle_pct = 63;
    cfg_all(30000, 30000, 10000, 60000, 500, -1000, 3, 1);
    add_random(300, 9000);
    wait_idle();

    // Receiver holds off long enough for the block to fill and stall input.
    send_idle_pct = 0;
    recv_stall_pct = 63;
    cfg_all(0, 0, 0, 0, -32768, 32767, 255, 1);
    holdoff_req = 1'b1;
    add_random(300, 3);
    wait_idle();

    send_idle_pct = 38;
    recv_stall_pct = 38;
    cfg_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32767, -32768, 0, 0);
    add_random(150, 100000);
    wait_idle();

    // Sender pauses mid-phase until every outstanding result has drained.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    clock_ms = 32'hFFFF_F000;
    cfg_all(20, 20, 1, 1, 200, -200, 5, 2);
    add_random(150, 4);
    wait_idle();
    add_random(150, 4);
    wait_idle();

    send_idle_pct = 38;
    recv_stall_pct = 38;
    cfg_all(1000, 700, 100, 50, 500, -1000, 1, 3);
    add_random(300, 120);
    wait_idle();

    repeat (20) @(posedge clk);
    $display("run covered %0d items, %0d results, %0d input stall cycles",
             n_accepted, n_results, n_stalled);
    $display("car start/stop pulses %0d/%0d, grid priority requests %0d, mismatches %0d",
             n_car_start, n_car_stop, n_grid, n_mismatch);
    if (!failed && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/scsc_pkg.sv
sv/scsc_cfg.sv
sv/scsc_front.sv
sv/scsc_back.sv
sv/scsc_out_q.sv
sv/solar_charger_surplus_controller_core.sv
sim/tb_solar_charger_surplus_controller_core.sv
